[hdl/tbh_pkg.sv]
package tbh_pkg;

  localparam int unsigned SLOTS     = 16;
  localparam int unsigned SLOT_BITS = $clog2(SLOTS);
  localparam int unsigned CNT_BITS  = $clog2(SLOTS + 1);
  localparam int unsigned GEN_BITS  = 16;
  localparam int unsigned TIME_BITS = 48;
  localparam int unsigned STEP_BITS = 32;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_STOP    = 3'd1,
    OP_PAUSE   = 3'd2,
    OP_RESUME  = 3'd3,
    OP_RESTART = 3'd4,
    OP_QUERY   = 3'd5,
    OP_TICK    = 3'd6,
    OP_NOP     = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_RUN   = 2'd1,
    ST_PAUSE = 2'd2,
    ST_RSVD  = 2'd3
  } run_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_RSVD    = 2'd3
  } stat_e;

  // slot record kept in ram
  typedef struct packed {
    logic [1:0]           state;
    logic                 periodic;
    logic [GEN_BITS-1:0]  gen;
    logic [TIME_BITS-1:0] interval;
    logic [TIME_BITS-1:0] elapsed;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

endpackage

[hdl/tbh_ram.sv]
module tbh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hdl/tbh_mod.sv]
// iterative restoring remainder, one quotient bit per cycle
module tbh_mod (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tbh_pkg::TIME_BITS-1:0] num_i,
  input  logic [tbh_pkg::TIME_BITS-1:0] den_i,
  output logic                          done_o,
  output logic [tbh_pkg::TIME_BITS-1:0] rem_o
);

  localparam int unsigned TB = tbh_pkg::TIME_BITS;
  localparam int unsigned CB = $clog2(TB + 1);

  logic [TB-1:0] num_q, den_q, rem_q;
  logic [CB-1:0] cnt_q;
  logic          busy_q;
  logic [TB:0]   shifted;
  logic [TB:0]   diff;

  assign shifted = {rem_q, num_q[TB-1]};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CB'(TB);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CB'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[TB-2:0], 1'b0};
      if (!diff[TB]) begin
        rem_q <= diff[TB-1:0];
      end else begin
        rem_q <= shifted[TB-1:0];
      end
    end
  end

  assign rem_o = rem_q;

endmodule

[hdl/timer_bank_with_handles.sv]
// Timer bank of 16 one-shot or periodic timers addressed by slot and generation
// handles. Control ops (start, stop, pause, resume, restart, query) each go through
// one read of the slot ram, a check, a write back and the result beat. A tick
// walks every used slot through the slot ram, reading and checking each slot in
// S_TRD, S_TWAIT and S_TCHK, with a result beat for each expiry; a periodic expiry
// with a non-zero interval adds a bit-serial modulo. Each result beat is held
// until taken; the next item is accepted once the last beat of the current one
// has gone. Configuration via APB at 8*index.
module timer_bank_with_handles (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op[2:0], slot[6:3], handle_gen[22:7], periodic[23], period_ns[71:24],
  // step_ns[103:72]
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], out_slot[5:2], out_gen[21:6], run_state[23:22],
  // out_periodic[24], out_interval[72:25], out_elapsed[120:73],
  // out_remaining[168:121], fired[169]
  output logic [175:0] m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int unsigned SB = tbh_pkg::SLOT_BITS;
  localparam int unsigned CB = tbh_pkg::CNT_BITS;
  localparam int unsigned GB = tbh_pkg::GEN_BITS;
  localparam int unsigned TB = tbh_pkg::TIME_BITS;
  localparam int unsigned SW = tbh_pkg::STEP_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_POP, S_RD, S_CHECK, S_TRD, S_TWAIT, S_TCHK, S_MOD, S_OUT
  } fsm_e;

  fsm_e fsm_q, fsm_after_q;

  logic [TB-1:0] min_q, max_q;
  logic [CB-1:0] free_cnt_q, used_q;

  tbh_pkg::op_e      op_q;
  logic [SB-1:0]     slot_q;
  logic [GB-1:0]     gen_q;
  logic              per_q;
  logic [TB-1:0]     req_q;
  logic [SW-1:0]     step_q;
  logic              newslot_q;
  logic [CB-1:0]     idx_q;
  tbh_pkg::slot_t    rec_q;

  // ram
  logic              ram_we;
  logic [SB-1:0]     ram_waddr, ram_raddr;
  tbh_pkg::slot_t    ram_wdata, ram_rdata;
  logic              fs_we;
  logic [SB-1:0]     fs_waddr, fs_raddr, fs_wdata, fs_rdata;

  tbh_ram #(.WIDTH(tbh_pkg::SLOT_W), .DEPTH(tbh_pkg::SLOTS)) u_slot_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  tbh_ram #(.WIDTH(SB), .DEPTH(tbh_pkg::SLOTS)) u_free_ram (
    .clk_i, .we_i(fs_we), .waddr_i(fs_waddr), .wdata_i(fs_wdata),
    .raddr_i(fs_raddr), .rdata_o(fs_rdata)
  );

  logic          mod_start, mod_done;
  logic [TB-1:0] mod_rem;

  logic [TB:0]   add_sum;
  logic [TB-1:0] sat_el;

  tbh_mod u_mod (
    .clk_i, .rst_ni, .start_i(mod_start), .num_i(sat_el),
    .den_i(ram_rdata.interval), .done_o(mod_done), .rem_o(mod_rem)
  );

  // apb
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == 4'd0) begin
      prdata = {{(64-TB){1'b0}}, min_q};
    end else if (paddr == 4'd8) begin
      prdata = {{(64-TB){1'b0}}, max_q};
    end
  end

  // input fields
  logic [2:0]    in_op;
  logic [SB-1:0] in_slot;
  logic [GB-1:0] in_gen;
  assign in_op   = s_axis_tdata[2:0];
  assign in_slot = s_axis_tdata[6:3];
  assign in_gen  = s_axis_tdata[22:7];

  assign s_axis_tready = (fsm_q == S_IDLE);

  logic [TB-1:0] clamp_iv;
  always_comb begin
    clamp_iv = req_q;
    if (req_q < min_q) begin
      clamp_iv = min_q;
    end else if (req_q > max_q) begin
      clamp_iv = max_q;
    end
  end

  logic handle_ok;
  assign handle_ok = ({1'b0, slot_q} < used_q) && (ram_rdata.gen == gen_q) &&
                     (ram_rdata.state != tbh_pkg::ST_FREE);

  assign add_sum = {1'b0, ram_rdata.elapsed} + {{(TB+1-SW){1'b0}}, step_q};
  assign sat_el  = add_sum[TB] ? tbh_pkg::TIME_MAX : add_sum[TB-1:0];

  logic [GB-1:0] gen_inc;
  assign gen_inc = (ram_rdata.gen + 1'b1 == '0) ? GB'(1) : ram_rdata.gen + 1'b1;

  logic [SB-1:0] idx_s;
  assign idx_s = idx_q[SB-1:0];

  always_comb begin
    ram_raddr = slot_q;
    if (fsm_q == S_TRD || fsm_q == S_TWAIT) begin
      ram_raddr = idx_s;
    end else if (fsm_q == S_POP) begin
      ram_raddr = fs_rdata;
    end
    fs_raddr  = SB'(free_cnt_q - 1'b1);
  end

  function automatic logic [TB-1:0] remain(input tbh_pkg::slot_t r);
    remain = (r.elapsed > r.interval) ? '0 : r.interval - r.elapsed;
  endfunction

  task automatic put(input tbh_pkg::stat_e st, input logic [SB-1:0] s,
                     input logic [GB-1:0] g, input logic [1:0] rs,
                     input logic p, input logic [TB-1:0] iv,
                     input logic [TB-1:0] el, input logic [TB-1:0] rm,
                     input logic fi, input logic la);
    m_axis_tdata <= {6'd0, fi, rm, el, iv, p, rs, g, s, st};
    m_axis_tlast <= la;
  endtask

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = rec_q;
    fs_we     = 1'b0;
    fs_waddr  = SB'(free_cnt_q);
    fs_wdata  = slot_q;
    mod_start = 1'b0;
    unique case (fsm_q)
      S_CHECK: begin
        if (op_q == tbh_pkg::OP_START) begin
          ram_we          = 1'b1;
          ram_wdata.state = tbh_pkg::ST_RUN;
          ram_wdata.periodic = per_q;
          ram_wdata.gen   = newslot_q ? GB'(1) : gen_inc;
          ram_wdata.interval = clamp_iv;
          ram_wdata.elapsed  = '0;
        end else if (handle_ok) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          unique case (op_q)
            tbh_pkg::OP_STOP: begin
              ram_wdata.state = tbh_pkg::ST_FREE;
              ram_wdata.periodic = 1'b0;
              ram_wdata.interval = '0;
              ram_wdata.elapsed  = '0;
              fs_we = (free_cnt_q < CB'(tbh_pkg::SLOTS));
            end
            tbh_pkg::OP_PAUSE: ram_wdata.state = tbh_pkg::ST_PAUSE;
            tbh_pkg::OP_RESUME: begin
              if (ram_rdata.state == tbh_pkg::ST_PAUSE) begin
                ram_wdata.state = tbh_pkg::ST_RUN;
              end
            end
            tbh_pkg::OP_RESTART: begin
              ram_wdata.state   = tbh_pkg::ST_RUN;
              ram_wdata.elapsed = '0;
            end
            default: ;
          endcase
        end
      end
      S_TCHK: begin
        ram_waddr = idx_s;
        fs_wdata  = idx_s;
        if (ram_rdata.state == tbh_pkg::ST_RUN) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          ram_wdata.elapsed = sat_el;
          if (sat_el >= ram_rdata.interval) begin
            if (!ram_rdata.periodic) begin
              ram_wdata.state = tbh_pkg::ST_FREE;
              ram_wdata.interval = '0;
              ram_wdata.elapsed  = '0;
              fs_we = (free_cnt_q < CB'(tbh_pkg::SLOTS));
            end else if (ram_rdata.interval == '0) begin
              ram_wdata.elapsed = '0;
            end else begin
              mod_start = 1'b1;
              ram_we    = 1'b0;
            end
          end
        end
      end
      S_MOD: begin
        ram_waddr = idx_s;
        if (mod_done) begin
          ram_we    = 1'b1;
          ram_wdata = rec_q;
          ram_wdata.elapsed = mod_rem;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q         <= S_IDLE;
      fsm_after_q   <= S_IDLE;
      min_q         <= TB'(1);
      max_q         <= tbh_pkg::TIME_MAX;
      free_cnt_q    <= '0;
      used_q        <= '0;
      m_axis_tvalid <= 1'b0;
      op_q          <= tbh_pkg::OP_NOP;
      idx_q         <= '0;
      newslot_q     <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr == 4'd0) begin
          min_q <= pwdata[TB-1:0];
        end else if (paddr == 4'd8) begin
          max_q <= pwdata[TB-1:0];
        end
      end
      unique case (fsm_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q   <= tbh_pkg::op_e'(in_op);
            slot_q <= in_slot;
            gen_q  <= in_gen;
            per_q  <= s_axis_tdata[23];
            req_q  <= s_axis_tdata[71:24];
            step_q <= s_axis_tdata[103:72];
            idx_q  <= '0;
            if (in_op == tbh_pkg::OP_START) begin
              if (free_cnt_q != '0) begin
                fsm_q <= S_POP;
              end else if (used_q < CB'(tbh_pkg::SLOTS)) begin
                slot_q    <= SB'(used_q);
                newslot_q <= 1'b1;
                used_q    <= used_q + 1'b1;
                fsm_q     <= S_RD;
              end else begin
                put(tbh_pkg::STAT_FULL, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0, 1'b1);
                m_axis_tvalid <= 1'b1;
                fsm_after_q   <= S_IDLE;
                fsm_q         <= S_OUT;
              end
            end else if (in_op == tbh_pkg::OP_TICK) begin
              fsm_q <= S_TRD;
            end else if (in_op == tbh_pkg::OP_NOP) begin
              put(tbh_pkg::STAT_OK, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0, 1'b1);
              m_axis_tvalid <= 1'b1;
              fsm_after_q   <= S_IDLE;
              fsm_q         <= S_OUT;
            end else begin
              fsm_q <= S_RD;
            end
          end
        end
        S_POP: begin
          // fs_rdata valid here, slot ram read issued
          slot_q     <= fs_rdata;
          newslot_q  <= 1'b0;
          free_cnt_q <= free_cnt_q - 1'b1;
          fsm_q      <= S_CHECK;
        end
        S_RD: fsm_q <= S_CHECK;
        S_CHECK: begin
          m_axis_tvalid <= 1'b1;
          fsm_after_q   <= S_IDLE;
          fsm_q         <= S_OUT;
          if (op_q == tbh_pkg::OP_START) begin
            put(tbh_pkg::STAT_OK, slot_q, ram_wdata.gen, tbh_pkg::ST_RUN, per_q,
                clamp_iv, '0, clamp_iv, 1'b0, 1'b1);
          end else if (!handle_ok) begin
            put(tbh_pkg::STAT_INVALID, slot_q, gen_q, '0, 1'b0, '0, '0, '0,
                1'b0, 1'b1);
          end else begin
            if (fs_we) begin
              free_cnt_q <= free_cnt_q + 1'b1;
            end
            put(tbh_pkg::STAT_OK, slot_q, ram_wdata.gen, ram_wdata.state,
                ram_wdata.periodic, ram_wdata.interval, ram_wdata.elapsed,
                remain(ram_wdata), 1'b0, 1'b1);
          end
        end
        S_TRD: begin
          if (idx_q >= used_q) begin
            put(tbh_pkg::STAT_OK, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0, 1'b1);
            m_axis_tvalid <= 1'b1;
            fsm_after_q   <= S_IDLE;
            fsm_q         <= S_OUT;
          end else begin
            fsm_q <= S_TWAIT;
          end
        end
        S_TWAIT: fsm_q <= S_TCHK;
        S_TCHK: begin
          rec_q <= ram_rdata;
          if (ram_rdata.state == tbh_pkg::ST_RUN && sat_el >= ram_rdata.interval) begin
            if (!ram_rdata.periodic) begin
              if (fs_we) begin
                free_cnt_q <= free_cnt_q + 1'b1;
              end
              put(tbh_pkg::STAT_OK, idx_s, ram_rdata.gen, tbh_pkg::ST_FREE, 1'b0,
                  ram_rdata.interval, sat_el, '0, 1'b1, 1'b0);
              m_axis_tvalid <= 1'b1;
              fsm_after_q   <= S_TRD;
              fsm_q         <= S_OUT;
              idx_q         <= idx_q + 1'b1;
            end else if (ram_rdata.interval == '0) begin
              put(tbh_pkg::STAT_OK, idx_s, ram_rdata.gen, tbh_pkg::ST_RUN, 1'b1,
                  '0, '0, '0, 1'b1, 1'b0);
              m_axis_tvalid <= 1'b1;
              fsm_after_q   <= S_TRD;
              fsm_q         <= S_OUT;
              idx_q         <= idx_q + 1'b1;
            end else begin
              fsm_q <= S_MOD;
            end
          end else begin
            idx_q <= idx_q + 1'b1;
            fsm_q <= S_TRD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            put(tbh_pkg::STAT_OK, idx_s, rec_q.gen, tbh_pkg::ST_RUN, 1'b1,
                rec_q.interval, mod_rem, rec_q.interval - mod_rem, 1'b1, 1'b0);
            m_axis_tvalid <= 1'b1;
            fsm_after_q   <= S_TRD;
            fsm_q         <= S_OUT;
            idx_q         <= idx_q + 1'b1;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            fsm_q         <= fsm_after_q;
          end
        end
        default: fsm_q <= S_IDLE;
      endcase
    end
  end

endmodule
